// ----- design/imws_pkg.sv -----
// Shared types, register codes and weight helpers for the IUPAC motif window scanner.
package imws_pkg;

  localparam int MASK_W     = 4;
  localparam int NPOS       = 32;
  localparam int IDX_W      = 5;
  localparam int LEN_W      = 6;
  localparam int SCORE_W    = 9;
  localparam int POS_W      = 16;
  localparam int WGT_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int GRP        = 8;
  localparam int GSUM_W     = 7;
  localparam int THR_W      = 11;

  localparam logic [CFG_IDX_W-1:0] REG_MASKS_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASKS_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRAND     = 3'd5;

  localparam logic MODE_BEST  = 1'b0;
  localparam logic MODE_FIRST = 1'b1;
  localparam logic STRAND_REV = 1'b1;

  typedef struct packed {
    logic [1:0] base_code;
    logic       last_base;
  } imws_in_t;

  typedef struct packed {
    logic               found;
    logic [POS_W-1:0]   match_position;
    logic [SCORE_W-1:0] window_score;
    logic [SCORE_W-1:0] mismatch_units;
  } imws_out_t;

  // Per-base bookkeeping that travels down the score pipeline
  typedef struct packed {
    logic             last;
    logic             win;
    logic             fresh;
    logic [POS_W-1:0] start;
  } imws_meta_t;

  // Settings the result stage needs
  typedef struct packed {
    logic             mode;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] mism;
  } imws_sel_cfg_t;

  // Twelfths earned by one base against one mask (mask 0 counts a quarter)
  function automatic logic [WGT_W-1:0] base_weight(input logic [MASK_W-1:0] mask,
                                                   input logic [1:0] b);
    logic [2:0]       cnt;
    logic [WGT_W-1:0] w;
    cnt = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
    if (mask == '0) begin
      w = 4'd3;
    end else if (!mask[b]) begin
      w = 4'd0;
    end else begin
      case (cnt)
        3'd1:    w = 4'd12;
        3'd2:    w = 4'd6;
        3'd3:    w = 4'd4;
        default: w = 4'd3;
      endcase
    end
    return w;
  endfunction

  function automatic logic [SCORE_W-1:0] times12(input logic [LEN_W-1:0] x);
    return {x, 3'b000} + {1'b0, x, 2'b00};
  endfunction

endpackage

// ----- design/imws_cell.sv -----
// One window cell: holds one target base, passes it on, and scores it against its mask.
module imws_cell import imws_pkg::*; (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [1:0]        base_in,
  input  logic [MASK_W-1:0] mask,
  input  logic              in_use,
  input  logic              strand,
  output logic [1:0]        base_out,
  output logic [WGT_W-1:0]  weight
);

  logic [1:0] base_r;

  // Advance the base one cell per accepted beat
  always_ff @(posedge clk) begin
    if (shift_en) begin
      base_r <= base_in;
    end
  end

  assign base_out = base_r;

  // Reverse strand compares the complement base
  assign weight = in_use ? base_weight(mask, (strand == STRAND_REV) ? ~base_r : base_r)
                         : '0;

endmodule

// ----- design/imws_score_tree.sv -----
// Two-stage registered adder tree that totals the cell weights into a window score.
module imws_score_tree import imws_pkg::*; #(
  parameter int N = 32
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [N-1:0][WGT_W-1:0]   weights,
  output logic [SCORE_W-1:0]        score
);

  localparam int NGRP     = (N + GRP - 1) / GRP;
  localparam int PAD_BITS = NGRP * GRP * WGT_W;

  logic [NGRP*GRP-1:0][WGT_W-1:0] wpad;
  logic [NGRP-1:0][GSUM_W-1:0]    grp_nxt;
  logic [NGRP-1:0][GSUM_W-1:0]    grp_r;
  logic [SCORE_W-1:0]             score_nxt;
  logic [SCORE_W-1:0]             score_r;

  assign wpad = PAD_BITS'(weights);

  // Sum each group of eight cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int e = 0; e < GRP; e++) begin
        grp_nxt[g] = grp_nxt[g] + GSUM_W'(wpad[g*GRP+e]);
      end
    end
  end

  // Sum the group totals
  always_comb begin
    score_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      score_nxt = score_nxt + SCORE_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grp_r   <= grp_nxt;
      score_r <= score_nxt;
    end
  end

  assign score = score_r;

endmodule

// ----- design/imws_select.sv -----
// Result stage: threshold test, best-window tracking and result formation.
module imws_select import imws_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               valid,
  input  imws_meta_t         meta,
  input  logic [SCORE_W-1:0] score,
  input  imws_sel_cfg_t      cfg,
  output logic               emit,
  output imws_out_t          result
);

  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [POS_W-1:0]   best_pos_r,   best_pos_nxt;
  logic [SCORE_W-1:0] best_miss_r,  best_miss_nxt;
  logic               first_hit_r,  first_hit_nxt;

  logic [SCORE_W-1:0]       best_eff;
  logic                     first_eff;
  logic signed [LEN_W:0]    diff;
  logic signed [THR_W-1:0]  diff_ext;
  logic signed [THR_W-1:0]  thr;
  logic [SCORE_W-1:0]       full;
  logic                     qual;
  logic                     keep;
  logic                     hit;

  // Threshold is twelve times (length - mismatches), may go negative
  assign diff     = $signed({1'b0, cfg.len}) - $signed({1'b0, cfg.mism});
  assign diff_ext = {{(THR_W-LEN_W-1){diff[LEN_W]}}, diff};
  assign thr      = (diff_ext <<< 3) + (diff_ext <<< 2);
  assign full     = times12(cfg.len);
  assign qual     = $signed({2'b00, score}) >= thr;

  // A fresh target starts from cleared bookkeeping
  assign best_eff  = meta.fresh ? '0 : best_score_r;
  assign first_eff = meta.fresh ? 1'b0 : first_hit_r;

  assign keep = meta.win && qual && (score > best_eff);
  assign hit  = (cfg.mode == MODE_FIRST) && !first_eff && meta.win && qual;

  always_comb begin
    best_score_nxt = meta.fresh ? '0 : best_score_r;
    best_pos_nxt   = meta.fresh ? '0 : best_pos_r;
    best_miss_nxt  = meta.fresh ? '0 : best_miss_r;
    first_hit_nxt  = first_eff | hit;
    if (keep) begin
      best_score_nxt = score;
      best_pos_nxt   = meta.start;
      best_miss_nxt  = full - score;
    end
  end

  // Form the result: first hit at once, otherwise a report on the last base (in first mode only if no hit)
  always_comb begin
    emit   = 1'b0;
    result = '0;
    if (hit) begin
      emit                  = 1'b1;
      result.found          = 1'b1;
      result.match_position = meta.start;
      result.window_score   = score;
      result.mismatch_units = full - score;
    end else if (meta.last) begin
      if (cfg.mode == MODE_BEST) begin
        emit = 1'b1;
        if (best_score_nxt != '0) begin
          result.found          = 1'b1;
          result.match_position = best_pos_nxt;
          result.window_score   = best_score_nxt;
          result.mismatch_units = best_miss_nxt;
        end
      end else if (!first_eff) begin
        emit = 1'b1;
      end
    end
    emit = emit && valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_pos_r   <= '0;
      best_miss_r  <= '0;
      first_hit_r  <= 1'b0;
    end else if (adv && valid) begin
      best_score_r <= best_score_nxt;
      best_pos_r   <= best_pos_nxt;
      best_miss_r  <= best_miss_nxt;
      first_hit_r  <= first_hit_nxt;
    end
  end

endmodule

// ----- design/iupac_motif_window_scanner_unit.sv -----
// Top level of the IUPAC motif window scanner: config registers, cell row and pipeline.
// The scanner takes one target base per cycle and scores the window that the base closes
// against up to 32 IUPAC mask positions. Bases shift down a row of cells, each of which
// weighs its base against the mask of its pattern position; a two-stage adder tree totals
// the row, and a result stage applies the threshold and tracks the best window. A result
// is carried through the cell row, both tree stages and the output register. The block
// sustains one base per cycle; input ready drops only while a new result is due and the
// previous one still waits at the output. Pattern registers are read live, so write them
// only while no beat is in flight. There is no clearing pass after reset.
module iupac_motif_window_scanner_unit import imws_pkg::*; #(
  parameter int MAX_PATTERN = 32,
  parameter int MAX_TARGET  = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  imws_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output imws_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_LIMIT = (MAX_PATTERN < NPOS) ? MAX_PATTERN : NPOS;
  localparam int NCELL     = LEN_LIMIT;
  localparam int SEEN_CAP  = MAX_TARGET + MAX_PATTERN;
  localparam int SEEN_W    = $clog2(SEEN_CAP + 1);

  // Configuration registers
  logic [CFG_DATA_W-1:0] masks_low_r;
  logic [CFG_DATA_W-1:0] masks_high_r;
  logic [LEN_W-1:0]      length_r;
  logic [LEN_W-1:0]      mism_r;
  logic                  mode_r;
  logic                  strand_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_low_r  <= '0;
      masks_high_r <= '0;
      length_r     <= LEN_W'(1);
      mism_r       <= '0;
      mode_r       <= MODE_BEST;
      strand_r     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MASKS_LOW:  masks_low_r  <= cfg_data;
        REG_MASKS_HIGH: masks_high_r <= cfg_data;
        REG_LENGTH:     length_r     <= cfg_data[LEN_W-1:0];
        REG_MISMATCH:   mism_r       <= cfg_data[LEN_W-1:0];
        REG_MODE:       mode_r       <= cfg_data[0];
        REG_STRAND:     strand_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp the pattern length into the supported range
  logic [LEN_W-1:0]             len_eff;
  logic [2*CFG_DATA_W-1:0]      masks_all;

  always_comb begin
    len_eff = length_r;
    if (length_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (length_r > LEN_W'(LEN_LIMIT)) begin
      len_eff = LEN_W'(LEN_LIMIT);
    end
  end

  assign masks_all = {masks_high_r, masks_low_r};

  // Pipeline control: everything holds while a due result cannot leave
  logic       adv;
  logic       accept;
  logic       emit;
  imws_out_t  result;
  logic       v0_r, v1_r, v2_r;
  imws_meta_t m0_r, m1_r, m2_r;
  logic       out_valid_r;
  imws_out_t  out_data_r;

  assign adv      = !(emit && out_valid_r && !out_ready);
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // Count bases of the current target and qualify the window this base closes
  logic [SEEN_W-1:0] seen_r, seen_nxt, seen_base, start_full;
  logic              done_r;
  logic              win;

  always_comb begin
    seen_base  = done_r ? '0 : seen_r;
    seen_nxt   = (seen_base < SEEN_W'(SEEN_CAP)) ? seen_base + SEEN_W'(1) : seen_base;
    start_full = seen_nxt - SEEN_W'(len_eff);
    win        = (seen_nxt >= SEEN_W'(len_eff)) && (start_full < SEEN_W'(MAX_TARGET));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      done_r <= in_data.last_base;
    end
  end

  // Cell row: cell 0 holds the newest base
  logic [NCELL-1:0][1:0]       cell_base;
  logic [NCELL-1:0][WGT_W-1:0] cell_wgt;

  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    logic [1:0]        base_in;
    logic [LEN_W-1:0]  fwd_pos;
    logic [IDX_W-1:0]  pos;
    logic [MASK_W-1:0] mask;
    logic              in_use;

    if (j == 0) begin : g_head
      assign base_in = in_data.base_code;
    end else begin : g_body
      assign base_in = cell_base[j-1];
    end

    // Forward strand reads the pattern from the far end of the window
    assign fwd_pos = len_eff - LEN_W'(1) - LEN_W'(j);
    assign pos     = (strand_r == STRAND_REV) ? IDX_W'(j) : fwd_pos[IDX_W-1:0];
    assign mask    = masks_all[pos*MASK_W +: MASK_W];
    assign in_use  = LEN_W'(j) < len_eff;

    imws_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .base_in  (base_in),
      .mask     (mask),
      .in_use   (in_use),
      .strand   (strand_r),
      .base_out (cell_base[j]),
      .weight   (cell_wgt[j])
    );
  end

  logic [SCORE_W-1:0] score;

  imws_score_tree #(.N(NCELL)) u_tree (
    .clk     (clk),
    .adv     (adv),
    .weights (cell_wgt),
    .score   (score)
  );

  // Carry the per-base bookkeeping alongside the tree stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v0_r <= accept;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m0_r.last  <= in_data.last_base;
      m0_r.win   <= win;
      m0_r.fresh <= done_r;
      m0_r.start <= POS_W'(start_full);
    end
    if (adv) begin
      m1_r <= m0_r;
      m2_r <= m1_r;
    end
  end

  imws_sel_cfg_t sel_cfg;

  assign sel_cfg.mode = mode_r;
  assign sel_cfg.len  = len_eff;
  assign sel_cfg.mism = mism_r;

  imws_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .valid  (v2_r),
    .meta   (m2_r),
    .score  (score),
    .cfg    (sel_cfg),
    .emit   (emit),
    .result (result)
  );

  // Output register: load a new beat, drop one that was taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/imws_checker.sv -----
// Port-level checks for the scanner, bound to its top level.
module imws_checker import imws_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input imws_out_t out_data
);

  logic [SCORE_W:0] unit_sum;

  assign unit_sum = {1'b0, out_data.window_score} + {1'b0, out_data.mismatch_units};

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // Refuse a base beat only while a result beat is stalled at the output
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("base beat refused with no stalled result");

  // Report all-zero fields when nothing was found
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |->
      out_data.match_position == '0 && out_data.window_score == '0 &&
      out_data.mismatch_units == '0)
    else $error("not-found result carries nonzero fields");

  // Score plus missing units spans a whole pattern of at most 32 positions
  a_units: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |-> unit_sum != '0 && unit_sum <= 10'd384)
    else $error("score and mismatch units do not add up to a pattern");

  // Drop any result beat during reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

endmodule

bind iupac_motif_window_scanner_unit imws_checker u_imws_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
